### hdl/mrf_pkg.sv
// Modbus RTU request framer: shared types, codes and the CRC-16/Modbus byte step.
// Used by mrf_ctrl, mrf_dpath and modbus_rtu_request_framer_core. No dependencies.
package mrf_pkg;

  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WR1   = 2'd1;
  localparam logic [1:0] CMD_WR2   = 2'd2;
  localparam logic [1:0] CMD_BAD   = 2'd3;

  localparam logic [7:0] FUNC_READ = 8'h03;
  localparam logic [7:0] FUNC_WR1  = 8'h06;
  localparam logic [7:0] FUNC_WR2  = 8'h10;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam int unsigned IdxW = 4;
  localparam logic [IdxW-1:0] LAST_IDX_SHORT = 4'd5;
  localparam logic [IdxW-1:0] LAST_IDX_LONG  = 4'd10;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  dev_id;
    logic [15:0] start_addr;
    logic [15:0] count_or_value;
    logic [15:0] value_high;
    logic [15:0] value_low;
  } req_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_byte;
    logic       refused;
  } rsp_t;

  typedef enum logic [1:0] {
    SEL_BODY   = 2'd0,
    SEL_CRC_LO = 2'd1,
    SEL_CRC_HI = 2'd2,
    SEL_REFUSE = 2'd3
  } out_sel_e;

  typedef struct packed {
    logic     load;
    logic     advance;
    out_sel_e sel;
  } ctrl_t;

  typedef struct packed {
    logic body_last;
  } stat_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### hdl/modbus_rtu_request_framer_core.sv
// Modbus RTU request framer top level: one request in, frame bytes out, one per cycle while out_stall_i is low.
// Latency: first byte is offered the cycle after the request is taken.
// Throughput: a new request is taken only in idle, once the last frame byte or the refusal
// has been taken; the rate is set by the one-byte output lane and byte-wise CRC.
// Reset: asynchronous active low; state machine idle, link_up cleared.
// Depends on mrf_pkg, mrf_ctrl, mrf_dpath.
module modbus_rtu_request_framer_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  mrf_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output mrf_pkg::rsp_t out_data_o
);

  mrf_pkg::ctrl_t ctrl;
  mrf_pkg::stat_t stat;

  mrf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_cmd_i    (in_data_i.cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  mrf_dpath u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (in_data_i),
    .ctrl_i (ctrl),
    .stat_o (stat),
    .rsp_o  (out_data_o)
  );

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> !out_valid_o)
    else $error("request taken while frame in flight");

  a_refuse_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.refused) |-> out_data_o.last_byte)
    else $error("refusal not marked last");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && out_data_o.last_byte) |=> !out_valid_o)
    else $error("output continues after last byte");

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.load |-> (!in_stall_o && in_valid_i && !out_valid_o))
    else $error("datapath load outside an accepted request");

endmodule

### hdl/mrf_ctrl.sv
// Modbus RTU request framer: sequencing state machine and link_up register.
// Depends on mrf_pkg.
module mrf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  input  logic          in_valid_i,
  input  logic [1:0]    in_cmd_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  mrf_pkg::stat_t stat_i,
  output mrf_pkg::ctrl_t ctrl_o
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_BODY   = 5'b00010,
    ST_CRC_LO = 5'b00100,
    ST_CRC_HI = 5'b01000,
    ST_REFUSE = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   link_up_q;
  logic   out_take;

  assign out_take = out_valid_o && !out_stall_i;

  always_comb begin
    state_d        = state_q;
    in_stall_o     = 1'b1;
    out_valid_o    = 1'b0;
    ctrl_o.load    = 1'b0;
    ctrl_o.advance = 1'b0;
    ctrl_o.sel     = mrf_pkg::SEL_BODY;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i && in_cmd_i != mrf_pkg::CMD_BAD) begin
          if (link_up_q) begin
            ctrl_o.load = 1'b1;
            state_d     = ST_BODY;
          end else begin
            state_d = ST_REFUSE;
          end
        end
      end
      ST_BODY: begin
        out_valid_o    = 1'b1;
        ctrl_o.advance = out_take;
        if (out_take && stat_i.body_last) begin
          state_d = ST_CRC_LO;
        end
      end
      ST_CRC_LO: begin
        out_valid_o = 1'b1;
        ctrl_o.sel  = mrf_pkg::SEL_CRC_LO;
        if (out_take) begin
          state_d = ST_CRC_HI;
        end
      end
      ST_CRC_HI: begin
        out_valid_o = 1'b1;
        ctrl_o.sel  = mrf_pkg::SEL_CRC_HI;
        if (out_take) begin
          state_d = ST_IDLE;
        end
      end
      ST_REFUSE: begin
        out_valid_o = 1'b1;
        ctrl_o.sel  = mrf_pkg::SEL_REFUSE;
        if (out_take) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      link_up_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        link_up_q <= cfg_wdata_i;
      end
    end
  end

endmodule

### hdl/mrf_dpath.sv
// Modbus RTU request framer: request holding register, byte index, byte mux, CRC.
// Depends on mrf_pkg.
module mrf_dpath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mrf_pkg::req_t  req_i,
  input  mrf_pkg::ctrl_t ctrl_i,
  output mrf_pkg::stat_t stat_o,
  output mrf_pkg::rsp_t  rsp_o
);

  mrf_pkg::req_t             req_q;
  logic [15:0]               crc_q;
  logic [mrf_pkg::IdxW-1:0]  idx_q;
  logic [7:0]                body_byte;
  logic [7:0]                func;
  logic                      long_frame;

  assign long_frame = (req_q.cmd == mrf_pkg::CMD_WR2);

  always_comb begin
    case (req_q.cmd)
      mrf_pkg::CMD_READ: func = mrf_pkg::FUNC_READ;
      mrf_pkg::CMD_WR1:  func = mrf_pkg::FUNC_WR1;
      default:           func = mrf_pkg::FUNC_WR2;
    endcase
  end

  always_comb begin
    body_byte = 8'h00;
    case (idx_q)
      4'd0: body_byte = req_q.dev_id;
      4'd1: body_byte = func;
      4'd2: body_byte = req_q.start_addr[15:8];
      4'd3: body_byte = req_q.start_addr[7:0];
      4'd4: body_byte = long_frame ? 8'h00 : req_q.count_or_value[15:8];
      4'd5: body_byte = long_frame ? 8'h02 : req_q.count_or_value[7:0];
      4'd6: body_byte = 8'h04;
      4'd7: body_byte = req_q.value_high[15:8];
      4'd8: body_byte = req_q.value_high[7:0];
      4'd9: body_byte = req_q.value_low[15:8];
      4'd10: body_byte = req_q.value_low[7:0];
      default: body_byte = 8'h00;
    endcase
  end

  assign stat_o.body_last = long_frame ? (idx_q == mrf_pkg::LAST_IDX_LONG)
                                       : (idx_q == mrf_pkg::LAST_IDX_SHORT);

  always_comb begin
    rsp_o.tx_byte   = body_byte;
    rsp_o.last_byte = 1'b0;
    rsp_o.refused   = 1'b0;
    case (ctrl_i.sel)
      mrf_pkg::SEL_BODY:   rsp_o.tx_byte = body_byte;
      mrf_pkg::SEL_CRC_LO: rsp_o.tx_byte = crc_q[7:0];
      mrf_pkg::SEL_CRC_HI: begin
        rsp_o.tx_byte   = crc_q[15:8];
        rsp_o.last_byte = 1'b1;
      end
      default: begin
        rsp_o.tx_byte   = 8'h00;
        rsp_o.last_byte = 1'b1;
        rsp_o.refused   = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (ctrl_i.load) begin
      idx_q <= '0;
    end else if (ctrl_i.advance) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      req_q <= req_i;
      crc_q <= mrf_pkg::CRC_INIT;
    end else if (ctrl_i.advance) begin
      crc_q <= mrf_pkg::crc_byte(crc_q, body_byte);
    end
  end

endmodule

### tb/mrf_frame_checker.sv
// Frame checker for modbus_rtu_request_framer_core: tracks link_up, predicts frame bytes
// for every accepted request except CMD_BAD and compares each accepted output item field by field.
// Depends on mrf_pkg for the request/response structs and function codes.
`timescale 1ns / 100ps

module mrf_frame_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  input  logic          in_valid_i,
  input  logic          in_stall_i,
  input  mrf_pkg::req_t in_data_i,
  input  logic          out_valid_i,
  input  logic          out_stall_i,
  input  mrf_pkg::rsp_t out_data_i,
  output int            pending_o,
  output int            errors_o,
  output int            frames_o,
  output int            refusals_o,
  output int            bytes_o
);

  logic          link_up_q;
  mrf_pkg::rsp_t frame_bytes_q[$];
  int            mismatches    = 0;
  int            frames_seen   = 0;
  int            refusals_seen = 0;
  int            bytes_checked = 0;

  assign errors_o   = mismatches;
  assign frames_o   = frames_seen;
  assign refusals_o = refusals_seen;
  assign bytes_o    = bytes_checked;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t checker: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // bit-serial form of the reflected CRC
  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) begin
        c = c ^ mrf_pkg::CRC_POLY;
      end
    end
    return c;
  endfunction

  function automatic void predict_frame(input mrf_pkg::req_t r);
    logic [7:0]    body [0:10];
    int            n;
    logic [15:0]   crc;
    mrf_pkg::rsp_t b;
    if (r.cmd == mrf_pkg::CMD_BAD) begin
      return;
    end
    if (!link_up_q) begin
      b.tx_byte   = 8'h00;
      b.last_byte = 1'b1;
      b.refused   = 1'b1;
      frame_bytes_q = {frame_bytes_q, b};
      refusals_seen++;
      return;
    end
    body[0] = r.dev_id;
    case (r.cmd)
      mrf_pkg::CMD_READ: body[1] = mrf_pkg::FUNC_READ;
      mrf_pkg::CMD_WR1:  body[1] = mrf_pkg::FUNC_WR1;
      default:           body[1] = mrf_pkg::FUNC_WR2;
    endcase
    body[2] = r.start_addr[15:8];
    body[3] = r.start_addr[7:0];
    if (r.cmd == mrf_pkg::CMD_WR2) begin
      body[4]  = 8'h00;
      body[5]  = 8'h02;
      body[6]  = 8'h04;
      body[7]  = r.value_high[15:8];
      body[8]  = r.value_high[7:0];
      body[9]  = r.value_low[15:8];
      body[10] = r.value_low[7:0];
      n = 11;
    end else begin
      body[4] = r.count_or_value[15:8];
      body[5] = r.count_or_value[7:0];
      n = 6;
    end
    crc = mrf_pkg::CRC_INIT;
    b.refused   = 1'b0;
    b.last_byte = 1'b0;
    for (int i = 0; i < n; i++) begin
      crc = crc16_update(crc, body[i]);
      b.tx_byte = body[i];
      frame_bytes_q = {frame_bytes_q, b};
    end
    b.tx_byte = crc[7:0];
    frame_bytes_q = {frame_bytes_q, b};
    b.tx_byte   = crc[15:8];
    b.last_byte = 1'b1;
    frame_bytes_q = {frame_bytes_q, b};
    frames_seen++;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    mrf_pkg::rsp_t want;
    if (!rst_ni) begin
      link_up_q <= 1'b0;
      pending_o <= 0;
      frame_bytes_q.delete();
    end else begin
      if (cfg_we_i) begin
        link_up_q <= cfg_wdata_i;
      end
      if (in_valid_i && !in_stall_i) begin
        predict_frame(in_data_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (frame_bytes_q.size() == 0) begin
          report_mismatch("unexpected item", int'(out_data_i), -1);
        end else begin
          want = frame_bytes_q.pop_front();
          bytes_checked++;
          if (out_data_i.tx_byte != want.tx_byte) begin
            report_mismatch("tx_byte", int'(out_data_i.tx_byte), int'(want.tx_byte));
          end
          if (out_data_i.last_byte != want.last_byte) begin
            report_mismatch("last_byte", int'(out_data_i.last_byte), int'(want.last_byte));
          end
          if (out_data_i.refused != want.refused) begin
            report_mismatch("refused", int'(out_data_i.refused), int'(want.refused));
          end
        end
      end
      pending_o <= frame_bytes_q.size();
    end
  end

endmodule

### tb/tb_modbus_rtu_request_framer_core.sv
// Testbench top for modbus_rtu_request_framer_core: clock, reset, link_up writes and
// request stimulus under several idle/stall mixes; checking is done in mrf_frame_checker.
// Depends on mrf_pkg, mrf_frame_checker and the framer RTL.
`timescale 1ns / 100ps

module tb_modbus_rtu_request_framer_core;

  localparam int WatchLimit   = 2000;
  localparam int SettleCycles = 20;
  localparam int HoldCycles   = 150;

  logic          clk_i     = 1'b0;
  logic          rst_ni    = 1'b0;
  logic          cfg_we    = 1'b0;
  logic          cfg_wdata = 1'b0;
  logic          in_valid  = 1'b0;
  mrf_pkg::req_t in_data   = '0;
  logic          out_stall = 1'b0;
  logic          in_stall;
  logic          out_valid;
  mrf_pkg::rsp_t out_data;

  int pending;
  int errors;
  int frames;
  int refusals;
  int bytes_checked;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int holds_asked   = 0;
  int holds_given   = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;
  int items_sent    = 0;

  always #6 clk_i = ~clk_i;

  modbus_rtu_request_framer_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  mrf_frame_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_i (in_stall),
    .in_data_i  (in_data),
    .out_valid_i(out_valid),
    .out_stall_i(out_stall),
    .out_data_i (out_data),
    .pending_o  (pending),
    .errors_o   (errors),
    .frames_o   (frames),
    .refusals_o (refusals),
    .bytes_o    (bytes_checked)
  );

  // output side: random stall, or a long hold-off when requested
  initial begin
    forever begin
      @(posedge clk_i);
      if (holds_asked != holds_given) begin
        holds_given = holds_asked;
        hold_left   = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic mrf_pkg::req_t make_req(input logic [1:0] cmd, input logic [7:0] id,
                                             input logic [15:0] addr, input logic [15:0] cv,
                                             input logic [15:0] vh, input logic [15:0] vl);
    mrf_pkg::req_t r;
    r.cmd            = cmd;
    r.dev_id         = id;
    r.start_addr     = addr;
    r.count_or_value = cv;
    r.value_high     = vh;
    r.value_low      = vl;
    return r;
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic mrf_pkg::req_t rand_request();
    mrf_pkg::req_t r;
    r.cmd            = ($urandom_range(99) < 5) ? mrf_pkg::CMD_BAD : 2'($urandom_range(2));
    r.dev_id         = 8'(pick_word() >> 8);
    r.start_addr     = pick_word();
    r.count_or_value = pick_word();
    r.value_high     = pick_word();
    r.value_low      = pick_word();
    return r;
  endfunction

  task automatic offer_request(input mrf_pkg::req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk_i); while (in_stall);
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic set_link(input logic up);
    drain_results();
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= up;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_random(input int n, input int send_pct, input int rcv_pct);
    mrf_pkg::req_t r;
    int            framed;
    framed        = 0;
    send_idle_pct = send_pct;
    stall_pct     = rcv_pct;
    while (framed < n) begin
      r = rand_request();
      offer_request(r);
      if (r.cmd != mrf_pkg::CMD_BAD) begin
        framed++;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 30;
    stall_pct     = 30;
    set_link(1'b0);
    offer_request(make_req(mrf_pkg::CMD_READ, 8'h01, 16'h0000, 16'h0001, 16'h0000, 16'h0000));
    offer_request(make_req(mrf_pkg::CMD_WR1, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    offer_request(make_req(mrf_pkg::CMD_WR2, 8'h00, 16'h1234, 16'h0000, 16'hFFFF, 16'h0000));
    offer_request(make_req(mrf_pkg::CMD_BAD, 8'h05, 16'h0000, 16'h0000, 16'h0000, 16'h0000));

    set_link(1'b1);
    offer_request(make_req(mrf_pkg::CMD_READ, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    offer_request(make_req(mrf_pkg::CMD_READ, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    offer_request(make_req(mrf_pkg::CMD_READ, 8'h01, 16'h0000, 16'h000A, 16'h0000, 16'h0000));
    offer_request(make_req(mrf_pkg::CMD_WR1, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    offer_request(make_req(mrf_pkg::CMD_WR1, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    offer_request(make_req(mrf_pkg::CMD_WR1, 8'h11, 16'h0001, 16'h0003, 16'h0000, 16'h0000));
    offer_request(make_req(mrf_pkg::CMD_WR2, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    offer_request(make_req(mrf_pkg::CMD_WR2, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    offer_request(make_req(mrf_pkg::CMD_WR2, 8'h7F, 16'h8000, 16'h1234, 16'hFFFF, 16'h0000));
    offer_request(make_req(mrf_pkg::CMD_WR2, 8'h80, 16'h00FF, 16'h0000, 16'h0000, 16'hFFFF));
    offer_request(make_req(mrf_pkg::CMD_BAD, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    offer_request(make_req(mrf_pkg::CMD_BAD, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    offer_request(make_req(mrf_pkg::CMD_READ, 8'hA5, 16'h5A5A, 16'hA5A5, 16'h0000, 16'h0000));

    run_random(70, 0, 0);

    // output held off while requests keep coming, so the input backs up
    drain_results();
    send_idle_pct = 0;
    stall_pct     = 0;
    holds_asked++;
    run_random(20, 0, 0);
    drain_results();

    run_random(70, 71, 0);
    set_link(1'b0);
    run_random(15, 0, 71);
    set_link(1'b1);
    run_random(70, 0, 71);
    run_random(70, 30, 30);

    drain_results();
    repeat (SettleCycles) @(posedge clk_i);

    $display("summary: %0d requests offered, %0d frames and %0d refusals predicted",
             items_sent, frames, refusals);
    $display("summary: %0d bytes checked; link down and up, all idle mixes, %0d-cycle hold-off",
             bytes_checked, HoldCycles);
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
